### rtl/ptmck_pkg.sv
// ----------------------------------------------------------------------------
// ptmck_pkg: shared types and constants for the Morton cell key block
// Register map, pipeline control bundle and fixed field widths.
// ----------------------------------------------------------------------------
package ptmck_pkg;

   localparam int DEF_COORD_WIDTH = 32;
   localparam int DEF_MAX_HEIGHT  = 21;

   localparam int KEY_WIDTH       = 64;
   localparam int CFG_DATA_WIDTH  = 32;
   localparam int SCALE_WIDTH     = 32;
   localparam int HEIGHT_WIDTH    = 5;
   localparam int KEY_POS_WIDTH   = 6;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int AXIS_COUNT      = 3;

   localparam logic [CFG_DATA_WIDTH-1:0] SCALE_RESET  = 32'd65536;
   localparam logic [HEIGHT_WIDTH-1:0]   HEIGHT_RESET = 5'd10;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MIN_X       = 3'd0,
      CSR_MIN_Y       = 3'd1,
      CSR_MIN_Z       = 3'd2,
      CSR_CELL_SCALE  = 3'd3,
      CSR_TREE_HEIGHT = 3'd4
   } csr_reg_type;

   // load enables of the four pipeline stages
   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
      logic s4_en;
   } pipe_ctl_type;

endpackage

### rtl/ptmck_lane.sv
// ----------------------------------------------------------------------------
// ptmck_lane: one axis of the cell index datapath
// Offset from box minimum, fixed-point scale, floor and clamp to 0..2^h-1.
// ----------------------------------------------------------------------------
module ptmck_lane import ptmck_pkg::*; #(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  pipe_ctl_type              ctl,
   input  logic [COORD_WIDTH-1:0]    coord,
   input  logic [CFG_DATA_WIDTH-1:0] min_val,
   input  logic [SCALE_WIDTH-1:0]    scale,
   input  logic [HEIGHT_WIDTH-1:0]   height_eff,
   output logic [MAX_HEIGHT-1:0]     idx,
   output logic                      clamp
);

   localparam int HI_W   = (COORD_WIDTH > 32) ? COORD_WIDTH - 32 : 1;
   localparam int HI_P_W = HI_W + 32;
   localparam int IDX_W  = HI_W + 33;

   // stage 1: signed difference, one bit wider than the coordinate
   logic [COORD_WIDTH+31:0] min_wide;
   logic [COORD_WIDTH-1:0]  min_cw;
   logic [COORD_WIDTH:0]    diff_in, diff_ff;

   assign min_wide = (COORD_WIDTH+32)'(min_val);
   assign min_cw   = min_wide[COORD_WIDTH-1:0];
   assign diff_in  = {coord[COORD_WIDTH-1], coord} - {min_cw[COORD_WIDTH-1], min_cw};

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         diff_ff <= diff_in;
      end
   end

   // stage 2: offset split into a low 32-bit and a high slice, each times the scale
   logic [63:0]        d_pad;
   logic [63:0]        lo_in, lo_ff;
   logic [HI_P_W-1:0]  hi_in, hi_ff;
   logic               neg_ff;

   assign d_pad = 64'(diff_ff[COORD_WIDTH-1:0]);
   assign lo_in = 64'(d_pad[31:0]) * 64'(scale);
   assign hi_in = HI_P_W'(d_pad[HI_W+31:32]) * HI_P_W'(scale);

   always_ff @(posedge clock) begin
      if (ctl.s2_en) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         neg_ff <= diff_ff[COORD_WIDTH];
      end
   end

   // stage 3: floor (drop 32 fraction bits) and clamp
   logic [IDX_W-1:0]      sum;
   logic [IDX_W-1:0]      max_idx;
   logic [MAX_HEIGHT-1:0] idx_in, idx_ff;
   logic                  clamp_in, clamp_ff;

   assign sum     = IDX_W'(hi_ff) + IDX_W'(lo_ff[63:32]);
   assign max_idx = (IDX_W'(1) << height_eff) - IDX_W'(1);

   always_comb begin
      priority if (scale == '0) begin
         idx_in   = '0;
         clamp_in = 1'b0;
      end else if (neg_ff) begin
         idx_in   = '0;
         clamp_in = 1'b1;
      end else if (sum > max_idx) begin
         idx_in   = max_idx[MAX_HEIGHT-1:0];
         clamp_in = 1'b1;
      end else begin
         idx_in   = sum[MAX_HEIGHT-1:0];
         clamp_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s3_en) begin
         idx_ff   <= idx_in;
         clamp_ff <= clamp_in;
      end
   end

   assign idx   = idx_ff;
   assign clamp = clamp_ff;

endmodule

### rtl/ptmck_merge.sv
// ----------------------------------------------------------------------------
// ptmck_merge: key assembly and output register
// Interleaves the three axis indices (x, y, z, MSB first) under a leading one.
// ----------------------------------------------------------------------------
module ptmck_merge import ptmck_pkg::*; #(
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                    clock,
   input  pipe_ctl_type            ctl,
   input  logic [MAX_HEIGHT-1:0]   idx_x,
   input  logic [MAX_HEIGHT-1:0]   idx_y,
   input  logic [MAX_HEIGHT-1:0]   idx_z,
   input  logic [AXIS_COUNT-1:0]   clamp,
   input  logic [HEIGHT_WIDTH-1:0] height_eff,
   output logic [KEY_WIDTH-1:0]    cell_key,
   output logic                    clamped
);

   logic [AXIS_COUNT*MAX_HEIGHT-1:0] interleaved;
   logic [KEY_POS_WIDTH-1:0]         lead_pos;
   logic [KEY_WIDTH-1:0]             key_in, key_ff;
   logic                             clamped_ff;

   // index bits at or above the height are zero after the clamp
   always_comb begin
      for (int b = 0; b < MAX_HEIGHT; b++) begin
         interleaved[AXIS_COUNT*b+2] = idx_x[b];
         interleaved[AXIS_COUNT*b+1] = idx_y[b];
         interleaved[AXIS_COUNT*b]   = idx_z[b];
      end
   end

   assign lead_pos = KEY_POS_WIDTH'(AXIS_COUNT) * KEY_POS_WIDTH'(height_eff);
   assign key_in   = KEY_WIDTH'(interleaved) | (KEY_WIDTH'(1) << lead_pos);

   always_ff @(posedge clock) begin
      if (ctl.s4_en) begin
         key_ff     <= key_in;
         clamped_ff <= |clamp;
      end
   end

   assign cell_key = key_ff;
   assign clamped  = clamped_ff;

endmodule

### rtl/point_to_morton_cell_key.sv
// ----------------------------------------------------------------------------
// point_to_morton_cell_key: octree cell key from a 3D fixed-point point
// Box offset, scale, floor/clamp per axis in three lanes, then Morton merge.
// ----------------------------------------------------------------------------
// Takes one point per clock while no stalled result fills the pipeline and
// returns one key per point, in order, through the registered stages offset,
// multiply, floor/clamp and interleave. The rate is set by the four-stage
// pipeline, which holds up to four points; a stalled result blocks the input
// only once every stage is full. Each axis runs in its own lane with two
// parallel multipliers (low 32-bit and high slice of the offset times
// cell_scale). Registers are written through the csr port (0 min_x, 1 min_y,
// 2 min_z, 3 cell_scale, 4 tree_height), which is always ready; other indexes
// are ignored. Write them only while no transaction is in flight.
module point_to_morton_cell_key import ptmck_pkg::*; #(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [COORD_WIDTH-1:0]     req_coord_x,
   input  logic [COORD_WIDTH-1:0]     req_coord_y,
   input  logic [COORD_WIDTH-1:0]     req_coord_z,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [KEY_WIDTH-1:0]       rsp_cell_key,
   output logic                       rsp_clamped,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_DATA_WIDTH-1:0]  csr_wdata
);

   // configuration registers
   logic [CFG_DATA_WIDTH-1:0] min_x_ff, min_y_ff, min_z_ff;
   logic [SCALE_WIDTH-1:0]    scale_ff;
   logic [HEIGHT_WIDTH-1:0]   height_ff;
   logic [HEIGHT_WIDTH-1:0]   height_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff  <= '0;
         min_y_ff  <= '0;
         min_z_ff  <= '0;
         scale_ff  <= SCALE_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_X:       min_x_ff  <= csr_wdata;
            CSR_MIN_Y:       min_y_ff  <= csr_wdata;
            CSR_MIN_Z:       min_z_ff  <= csr_wdata;
            CSR_CELL_SCALE:  scale_ff  <= csr_wdata;
            CSR_TREE_HEIGHT: height_ff <= csr_wdata[HEIGHT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign height_eff = (int'(height_ff) > MAX_HEIGHT) ? HEIGHT_WIDTH'(MAX_HEIGHT) : height_ff;

   // pipeline occupancy; a stage loads when it is empty or its successor moves
   logic [3:0]   valid_ff, valid_in;
   pipe_ctl_type ctl;

   always_comb begin
      ctl.s4_en = !valid_ff[3] || rsp_ready;
      ctl.s3_en = !valid_ff[2] || ctl.s4_en;
      ctl.s2_en = !valid_ff[1] || ctl.s3_en;
      ctl.s1_en = !valid_ff[0] || ctl.s2_en;
   end

   assign req_ready = ctl.s1_en;

   always_comb begin
      valid_in[0] = ctl.s1_en ? req_valid   : valid_ff[0];
      valid_in[1] = ctl.s2_en ? valid_ff[0] : valid_ff[1];
      valid_in[2] = ctl.s3_en ? valid_ff[1] : valid_ff[2];
      valid_in[3] = ctl.s4_en ? valid_ff[2] : valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[3];

   // axis lanes
   logic [MAX_HEIGHT-1:0] idx_x, idx_y, idx_z;
   logic [AXIS_COUNT-1:0] clamp;

   ptmck_lane #(.COORD_WIDTH(COORD_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_lane_x (
      .clock      (clock),
      .ctl        (ctl),
      .coord      (req_coord_x),
      .min_val    (min_x_ff),
      .scale      (scale_ff),
      .height_eff (height_eff),
      .idx        (idx_x),
      .clamp      (clamp[0])
   );

   ptmck_lane #(.COORD_WIDTH(COORD_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_lane_y (
      .clock      (clock),
      .ctl        (ctl),
      .coord      (req_coord_y),
      .min_val    (min_y_ff),
      .scale      (scale_ff),
      .height_eff (height_eff),
      .idx        (idx_y),
      .clamp      (clamp[1])
   );

   ptmck_lane #(.COORD_WIDTH(COORD_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_lane_z (
      .clock      (clock),
      .ctl        (ctl),
      .coord      (req_coord_z),
      .min_val    (min_z_ff),
      .scale      (scale_ff),
      .height_eff (height_eff),
      .idx        (idx_z),
      .clamp      (clamp[2])
   );

   ptmck_merge #(.MAX_HEIGHT(MAX_HEIGHT)) u_merge (
      .clock      (clock),
      .ctl        (ctl),
      .idx_x      (idx_x),
      .idx_y      (idx_y),
      .idx_z      (idx_z),
      .clamp      (clamp),
      .height_eff (height_eff),
      .cell_key   (rsp_cell_key),
      .clamped    (rsp_clamped)
   );

`ifndef ASSERT_OFF
   // leading one sits right above the 3*h index bits
   a_key_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cell_key >> (KEY_POS_WIDTH'(AXIS_COUNT) * KEY_POS_WIDTH'(height_eff)))
                    == KEY_WIDTH'(1))
      else $error("cell key leading bit misplaced");

   // zero scale maps every point to cell zero without a clamp
   a_zero_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && scale_ff == '0) |->
         (!rsp_clamped && rsp_cell_key == (KEY_WIDTH'(1)
            << (KEY_POS_WIDTH'(AXIS_COUNT) * KEY_POS_WIDTH'(height_eff)))))
      else $error("zero scale produced nonzero cell or clamp");

   // a full pipeline behind a stalled result must not take input
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff == 4'b1111 && !rsp_ready) |-> !req_ready)
      else $error("input accepted into full stalled pipeline");

   // a held result stays put while the consumer stalls
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_cell_key)
                                      && $stable(rsp_clamped)))
      else $error("stalled result changed");
`endif

endmodule
